>>> rtl/iir_pkg.sv
// shared constants and types of the state-space iir filter
package iir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int STATE_W   = 24;
    localparam int PROD_W    = COEF_W + STATE_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_BITS = 14;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WEIGHT_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_1   = 3'd4;

    localparam logic signed [COEF_W-1:0] DIRECT_GAIN_RESET = 18'sd16384;

    // datapath commands from the controller
    typedef struct packed {
        logic load;    // first product from the incoming sample, accumulators preset
        logic mul;     // product of the current step
        logic acc;     // add the previous product
        logic finish;  // saturate, write output, shift the delay line
    } dp_cmd_t;

endpackage

>>> rtl/iir_filter_state_space.sv
// top level of the state-space iir filter (direct form ii equivalent)
//
//  channel | signals                          | transfer
//  --------+----------------------------------+---------------------------------
//  input   | in_valid, in_ready, sample_in    | transaction when valid & ready
//  output  | out_valid, out_ready, sample_out | transaction when valid & ready
//  config  | cfg_we, cfg_index, cfg_data      | write when cfg_we, no wait
//
// each sample runs 2*ORDER+1 products through the single shared multiplier,
// then a finishing step saturates the results and shifts the delay line
// reset clears the delay line and loads the default coefficients (unit gain)
// the output register frees the input side; a new sample is taken while the
// last result waits, and only the finishing cycle stalls on a full output

module iir_filter_state_space #(
    parameter int ORDER = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [iir_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [iir_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                cfg_we,
    input  logic [iir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iir_pkg::COEF_W-1:0]          cfg_data
);
    import iir_pkg::*;

    localparam int STEP_W = $clog2(2 * ORDER + 1);

    dp_cmd_t           cmd;
    logic [STEP_W-1:0] step;

    iir_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .step      (step)
    );

    iir_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .step       (step),
        .sample_in  (sample_in),
        .sample_out (sample_out)
    );

endmodule

>>> rtl/iir_ctrl.sv
// sequencer that steps the shared multiplier through one sample
module iir_ctrl #(
    parameter int ORDER = 3,
    localparam int STEP_W = $clog2(2 * ORDER + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output iir_pkg::dp_cmd_t  cmd,
    output logic [STEP_W-1:0] step
);
    import iir_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * ORDER);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_W'(1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.mul   = 1'b1;
                cmd.acc   = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign step      = step_reg;

endmodule

>>> rtl/iir_dp.sv
// coefficient registers, delay line, shared multiplier and accumulators
module iir_dp #(
    parameter int ORDER = 3,
    localparam int STEP_W = $clog2(2 * ORDER + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [iir_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [iir_pkg::COEF_W-1:0]              cfg_data,
    input  iir_pkg::dp_cmd_t                        cmd,
    input  logic [STEP_W-1:0]                       step,
    input  logic signed [iir_pkg::SAMPLE_W-1:0]     sample_in,
    output logic signed [iir_pkg::SAMPLE_W-1:0]     sample_out
);
    import iir_pkg::*;

    localparam int SH_W = ACC_W - FRAC_BITS;

    logic signed [COEF_W-1:0]  direct_gain_reg;
    logic signed [COEF_W-1:0]  out_weight_reg [ORDER];
    logic signed [COEF_W-1:0]  feedback_reg [ORDER];
    logic signed [STATE_W-1:0] delay_reg [ORDER];

    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       prod_to_y_reg, prod_to_y_next;
    logic [ACC_W-1:0]           acc_y_reg, acc_y_next;
    logic [ACC_W-1:0]           acc_s_reg, acc_s_next;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;

    logic [STEP_W-1:0]         tap;
    logic signed [COEF_W-1:0]  op_a;
    logic signed [STATE_W-1:0] op_b;
    logic [ACC_W-1:0]          prod_ext;
    logic [ACC_W-1:0]          y_sum;
    logic [ACC_W-1:0]          s_sum;
    logic [SH_W-1:0]           y_sh;
    logic [SH_W-1:0]           s_sh;
    logic signed [STATE_W-1:0] s_new;

    // odd steps weigh the output, even steps the feedback, two steps per tap
    always_comb
    begin
        tap  = (step - STEP_W'(1)) >> 1;
        op_a = direct_gain_reg;
        op_b = STATE_W'(sample_in);
        if (!cmd.load)
        begin
            op_a = '0;
            op_b = '0;
            for (int i = 0; i < ORDER; i++)
            begin
                if (tap == STEP_W'(i))
                begin
                    op_a = step[0] ? out_weight_reg[i] : feedback_reg[i];
                    op_b = delay_reg[i];
                end
            end
        end
        prod_next      = PROD_W'(op_a * op_b);
        prod_to_y_next = cmd.load ? 1'b1 : step[0];
    end

    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        acc_y_next = acc_y_reg;
        acc_s_next = acc_s_reg;
        if (cmd.load)
        begin
            acc_y_next = '0;
            acc_s_next = {{(ACC_W - SAMPLE_W - FRAC_BITS){sample_in[SAMPLE_W-1]}},
                          sample_in, {FRAC_BITS{1'b0}}};
        end
        else if (cmd.acc)
        begin
            if (prod_to_y_reg)
            begin
                acc_y_next = acc_y_reg + prod_ext;
            end
            else
            begin
                acc_s_next = acc_s_reg + prod_ext;
            end
        end
    end

    // last product is still in flight at finish
    assign y_sum = prod_to_y_reg ? acc_y_reg + prod_ext : acc_y_reg;
    assign s_sum = prod_to_y_reg ? acc_s_reg : acc_s_reg + prod_ext;
    assign y_sh  = y_sum[ACC_W-1:FRAC_BITS];
    assign s_sh  = s_sum[ACC_W-1:FRAC_BITS];

    // clamp when the bits above the result width are not all sign copies
    always_comb
    begin
        if (y_sh[SH_W-1:SAMPLE_W-1] == '0 || y_sh[SH_W-1:SAMPLE_W-1] == '1)
        begin
            y_next = y_sh[SAMPLE_W-1:0];
        end
        else if (y_sh[SH_W-1])
        begin
            y_next = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end

        if (s_sh[SH_W-1:STATE_W-1] == '0 || s_sh[SH_W-1:STATE_W-1] == '1)
        begin
            s_new = s_sh[STATE_W-1:0];
        end
        else if (s_sh[SH_W-1])
        begin
            s_new = {1'b1, {(STATE_W - 1){1'b0}}};
        end
        else
        begin
            s_new = {1'b0, {(STATE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_gain_reg <= DIRECT_GAIN_RESET;
            for (int i = 0; i < ORDER; i++)
            begin
                out_weight_reg[i] <= '0;
                feedback_reg[i]   <= '0;
                delay_reg[i]      <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DIRECT_GAIN)
                begin
                    direct_gain_reg <= cfg_data;
                end
                for (int i = 0; i < ORDER; i++)
                begin
                    if (cfg_index == REG_OUT_WEIGHT_1 + CFG_IDX_W'(i))
                    begin
                        out_weight_reg[i] <= cfg_data;
                    end
                    if (cfg_index == REG_FEEDBACK_1 + CFG_IDX_W'(i))
                    begin
                        feedback_reg[i] <= cfg_data;
                    end
                end
            end
            if (cmd.finish)
            begin
                for (int i = ORDER - 1; i > 0; i--)
                begin
                    delay_reg[i] <= delay_reg[i-1];
                end
                delay_reg[0] <= s_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.mul)
        begin
            prod_reg      <= prod_next;
            prod_to_y_reg <= prod_to_y_next;
        end
        acc_y_reg <= acc_y_next;
        acc_s_reg <= acc_s_next;
        if (cmd.finish)
        begin
            y_reg <= y_next;
        end
    end

    assign sample_out = y_reg;

endmodule

>>> tb/tb_iir_filter_state_space.sv
// testbench of the state-space iir filter with a self-checking scoreboard
`timescale 1ns / 100ps

module tb_iir_filter_state_space;

    import iir_pkg::*;

    localparam int FILTER_ORDER  = 3;
    localparam int TAP_COUNT     = 3;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 94;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [COEF_W-1:0]    COEF_MAX   = 18'h1ffff;
    localparam logic [COEF_W-1:0]    COEF_MIN   = 18'h20000;
    localparam logic [COEF_W-1:0]    COEF_UNIT  = 18'd16384;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // scoreboard: own copy of coefficients and delay line, expected outputs in order
    class filter_scoreboard;
        logic signed [COEF_W-1:0]  gain;
        logic signed [COEF_W-1:0]  out_weight [TAP_COUNT];
        logic signed [COEF_W-1:0]  feedback [TAP_COUNT];
        logic signed [STATE_W-1:0] taps [TAP_COUNT];
        logic signed [SAMPLE_W-1:0] expected_out [$];
        int mismatches;

        function new();
            gain = DIRECT_GAIN_RESET;
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                out_weight[i] = '0;
                feedback[i]   = '0;
                taps[i]       = '0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            int n;
            n = int'(idx);
            if (idx == REG_DIRECT_GAIN)
                gain = data;
            else if (n >= int'(REG_OUT_WEIGHT_1) && n < int'(REG_OUT_WEIGHT_1) + TAP_COUNT)
                out_weight[n - int'(REG_OUT_WEIGHT_1)] = data;
            else if (n >= int'(REG_FEEDBACK_1) && n < int'(REG_FEEDBACK_1) + TAP_COUNT)
                feedback[n - int'(REG_FEEDBACK_1)] = data;
        endfunction

        // computes the response to one accepted sample and advances the delay line
        function void take_sample(logic signed [SAMPLE_W-1:0] u);
            longint acc_out;
            longint acc_state;
            longint y;
            longint s1;
            acc_out   = longint'(gain) * longint'(u);
            acc_state = longint'(u) * 64'sd16384;
            for (int i = 0; i < FILTER_ORDER; i++)
            begin
                acc_out   += longint'(out_weight[i]) * longint'(taps[i]);
                acc_state += longint'(feedback[i]) * longint'(taps[i]);
            end
            // arithmetic shift rounds toward minus infinity
            y  = acc_out >>> FRAC_BITS;
            s1 = acc_state >>> FRAC_BITS;
            if (y > 32767)
                y = 32767;
            else if (y < -32768)
                y = -32768;
            if (s1 > 8388607)
                s1 = 8388607;
            else if (s1 < -8388608)
                s1 = -8388608;
            for (int i = FILTER_ORDER - 1; i >= 1; i--)
                taps[i] = taps[i-1];
            taps[0] = s1[STATE_W-1:0];
            expected_out.push_back(y[SAMPLE_W-1:0]);
        endfunction

        function void check_sample_out(logic signed [SAMPLE_W-1:0] y);
            logic signed [SAMPLE_W-1:0] exp_y;
            if (expected_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output transaction, sample_out=%0d", $time, y);
            end
            else
            begin
                exp_y = expected_out.pop_front();
                if (y !== exp_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, exp_y, y);
                end
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0] cfg_data = '0;

    filter_scoreboard sb;
    logic [COEF_W-1:0] coef_set [7];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int idle_count = 0;

    iir_filter_state_space #(
        .ORDER(FILTER_ORDER)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample_out(sample_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // output side: check results, stall at random or for a long hold
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_sample_out(sample_out);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_coefs();
        for (int r = 0; r < 7; r++)
            write_reg(r[CFG_IDX_W-1:0], coef_set[r]);
        // the unused index must leave every coefficient alone
        write_reg(REG_UNUSED, COEF_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_sample(v);
    endtask

    // let the filter drain so the coefficients can be changed safely
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return SAMPLE_W'($urandom_range(511) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // kind 0: anything, kind 1: stable feedback, kind 2: mostly corner values
    function automatic logic [COEF_W-1:0] pick_coef(int kind, bit is_feedback);
        if (kind == 1)
        begin
            if (is_feedback)
                return COEF_W'($urandom_range(8000) - 4000);
            return COEF_W'($urandom_range(65535) - 32768);
        end
        if (kind == 2)
        begin
            case ($urandom_range(4))
                0: return COEF_MAX;
                1: return COEF_MIN;
                2: return '0;
                3: return COEF_UNIT;
                default: return COEF_W'($urandom);
            endcase
        end
        return COEF_W'($urandom);
    endfunction

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients give a straight pass-through
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        finish_phase();

        // largest coefficients drive output and state into positive/negative clamp
        for (int r = 0; r < 7; r++)
            coef_set[r] = COEF_MAX;
        program_coefs();
        repeat (3) send_sample(SAMPLE_MAX);
        repeat (3) send_sample(SAMPLE_MIN);
        finish_phase();

        for (int r = 0; r < 7; r++)
            coef_set[r] = COEF_MIN;
        program_coefs();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(-16'sd1);
        finish_phase();

        // pure three-sample delay through the last tap
        for (int r = 0; r < 7; r++)
            coef_set[r] = '0;
        coef_set[int'(REG_OUT_WEIGHT_1) + 2] = COEF_UNIT;
        program_coefs();
        repeat (4) send_sample(rand_sample());
        finish_phase();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            for (int r = 0; r < 7; r++)
                coef_set[r] = pick_coef(p % 3, r >= int'(REG_FEEDBACK_1));
            program_coefs();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold while samples keep coming, fills the block
                if (p == 4 && n == 10)
                    hold_left = HOLD_CYCLES;
                send_sample(rand_sample());
            end
            finish_phase();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
